@@ design/srap_pkg.sv @@
// srap_pkg: types, character codes and sizes shared by the servo reply parser
// no dependencies; compiled before the interfaces and all modules
`default_nettype none

package srap_pkg;

    localparam int DIGIT_SLOTS = 4;
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
    localparam int IDX_W       = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
    localparam int LIMIT_W     = 16;
    localparam int POS_W       = 12;

    // signed width that holds the decoded value of any DIGIT_SLOTS characters
    function automatic int value_width(input int slots);
        longint mag;
        int     w;
        mag = 0;
        for (int k = 0; k < slots; k++) begin
            mag = mag * 10 + 207;
        end
        w = $clog2(mag + 1) + 1;
        if (w < LIMIT_W + 2) begin
            w = LIMIT_W + 2;
        end
        return w;
    endfunction

    localparam int VAL_W = value_width(DIGIT_SLOTS);

    typedef logic [7:0]         t_byte;
    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [CNT_W-1:0]   t_count;
    typedef t_byte [DIGIT_SLOTS-1:0] t_digits;

    localparam t_limit LIMIT_RESET = 16'd4095;
    localparam t_pos   POS_MAX     = 12'd4095;

    localparam t_byte CH_AT    = 8'h40;
    localparam t_byte CH_ONE   = 8'h31;
    localparam t_byte CH_TWO   = 8'h32;
    localparam t_byte CH_FIVE  = 8'h35;
    localparam t_byte CH_SIX   = 8'h36;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_A     = 8'h41;
    localparam t_byte CH_C     = 8'h43;
    localparam t_byte CH_K     = 8'h4B;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_LF    = 8'h0A;

    typedef enum logic [3:0] {
        S_IDLE      = 4'd0,
        S_GOT_AT    = 4'd1,
        S_GOT_ONE   = 4'd2,
        S_GOT_SP    = 4'd3,
        S_GOT_A     = 4'd4,
        S_GOT_C     = 4'd5,
        S_GOT_K     = 4'd6,
        S_ACK_CR    = 4'd7,
        S_GOT_SP2   = 4'd8,
        S_GOT_FIVE  = 4'd9,
        S_GOT_SIX   = 4'd10,
        S_GOT_COMMA = 4'd11,
        S_GOT_TWO   = 4'd12,
        S_DIGITS    = 4'd13,
        S_POS_CR    = 4'd14
    } t_step;

    typedef struct packed {
        logic in_range;
        t_pos pos;
    } t_value_chk;

    typedef struct packed {
        logic ack_seen;
        logic position_valid;
        t_pos position;
        logic range_error;
        logic readback_done;
    } t_result;

endpackage

`default_nettype wire

@@ design/srap_if.sv @@
// srap_if: valid/ready channel interfaces for received bytes and parse results
// depends on srap_pkg
`default_nettype none

interface srap_rx_if;
    import srap_pkg::*;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srap_res_if;
    import srap_pkg::*;
    logic valid;
    logic ready;
    logic ack_seen;
    logic position_valid;
    t_pos position;
    logic range_error;
    logic readback_done;

    modport source (output valid, output ack_seen, output position_valid, output position,
                    output range_error, output readback_done, input ready);
    modport sink   (input valid, input ack_seen, input position_valid, input position,
                    input range_error, input readback_done, output ready);
endinterface

`default_nettype wire

@@ design/srap_value.sv @@
// srap_value: decimal value of the collected characters and its range check
// depends on srap_pkg
`default_nettype none

module srap_value (
    input  var srap_pkg::t_digits    i_digits,
    input  var srap_pkg::t_count     i_count,
    input  var srap_pkg::t_limit     i_limit,
    output var srap_pkg::t_value_chk o_chk
);
    import srap_pkg::*;

    logic signed [VAL_W-1:0] acc;
    logic signed [VAL_W-1:0] term;
    logic signed [VAL_W-1:0] lim_s;
    logic signed [VAL_W-1:0] pos_max_s;

    always_comb begin
        acc  = '0;
        term = '0;
        for (int j = 0; j < DIGIT_SLOTS; j++) begin
            if (j < int'(i_count)) begin
                term = $signed(VAL_W'(i_digits[j])) - $signed(VAL_W'(CH_ZERO));
                acc  = VAL_W'(acc * 10) + term;
            end
        end
    end

    always_comb begin
        lim_s          = $signed(VAL_W'(i_limit));
        pos_max_s      = $signed(VAL_W'(POS_MAX));
        o_chk.in_range = !acc[VAL_W-1] && (acc <= lim_s);
        o_chk.pos      = (acc > pos_max_s) ? POS_MAX : acc[POS_W-1:0];
    end

endmodule

`default_nettype wire

@@ design/srap_match.sv @@
// srap_match: reply matcher state, digit store and per-byte result logic
// depends on srap_pkg and srap_value
`default_nettype none

module srap_match (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_fire,
    input  var srap_pkg::t_byte   i_byte,
    input  var srap_pkg::t_limit  i_limit,
    output var srap_pkg::t_result o_result
);
    import srap_pkg::*;

    t_step      r_step;
    t_step      n_step;
    t_count     r_digit_count;
    t_count     n_digit_count;
    t_digits    r_digits;
    t_digits    n_digits;
    t_value_chk chk;

    srap_value u_value (
        .i_digits (r_digits),
        .i_count  (r_digit_count),
        .i_limit  (i_limit),
        .o_chk    (chk)
    );

    // next state, count and store
    always_comb begin
        n_step        = S_IDLE;
        n_digit_count = r_digit_count;
        n_digits      = r_digits;
        if (i_byte == CH_AT) begin
            n_step = S_GOT_AT;
        end else begin
            case (r_step)
                S_GOT_AT:    n_step = (i_byte == CH_ONE)   ? S_GOT_ONE   : S_IDLE;
                S_GOT_ONE:   n_step = (i_byte == CH_SPACE) ? S_GOT_SP    : S_IDLE;
                S_GOT_SP:    n_step = (i_byte == CH_A)     ? S_GOT_A     : S_IDLE;
                S_GOT_A:     n_step = (i_byte == CH_C)     ? S_GOT_C     : S_IDLE;
                S_GOT_C:     n_step = (i_byte == CH_K)     ? S_GOT_K     : S_IDLE;
                S_GOT_K: begin
                    if (i_byte == CH_CR) begin
                        n_step = S_ACK_CR;
                    end else if (i_byte == CH_SPACE) begin
                        n_step = S_GOT_SP2;
                    end
                end
                S_GOT_SP2:   n_step = (i_byte == CH_FIVE)  ? S_GOT_FIVE  : S_IDLE;
                S_GOT_FIVE:  n_step = (i_byte == CH_SIX)   ? S_GOT_SIX   : S_IDLE;
                S_GOT_SIX:   n_step = (i_byte == CH_COMMA) ? S_GOT_COMMA : S_IDLE;
                S_GOT_COMMA: n_step = (i_byte == CH_TWO)   ? S_GOT_TWO   : S_IDLE;
                S_GOT_TWO:   n_step = (i_byte == CH_COMMA) ? S_DIGITS    : S_IDLE;
                S_DIGITS: begin
                    if (i_byte == CH_CR) begin
                        n_digit_count = '0;
                        n_step        = chk.in_range ? S_POS_CR : S_IDLE;
                    end else if (int'(r_digit_count) < DIGIT_SLOTS) begin
                        n_digits[r_digit_count[IDX_W-1:0]] = i_byte;
                        n_digit_count = r_digit_count + 1'b1;
                        n_step        = S_DIGITS;
                    end else begin
                        // overflow drops the byte and clears the digit count
                        n_digit_count = '0;
                        n_step        = S_DIGITS;
                    end
                end
                default:     n_step = S_IDLE;
            endcase
        end
    end

    // result for the current byte
    always_comb begin
        o_result = '0;
        if (i_byte != CH_AT) begin
            case (r_step)
                S_ACK_CR: o_result.ack_seen = (i_byte == CH_LF);
                S_DIGITS: begin
                    if (i_byte == CH_CR) begin
                        o_result.position_valid = chk.in_range;
                        o_result.position       = chk.in_range ? chk.pos : '0;
                        o_result.range_error    = !chk.in_range;
                    end
                end
                S_POS_CR: o_result.readback_done = (i_byte == CH_LF);
                default:  o_result = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= S_IDLE;
            r_digit_count <= '0;
        end else if (i_fire) begin
            r_step        <= n_step;
            r_digit_count <= n_digit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_digits <= n_digits;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_result.ack_seen, o_result.position_valid,
                  o_result.range_error, o_result.readback_done}))
        else $error("more than one event on one byte");

    a_valid_waits_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.position_valid |=> r_step == S_POS_CR)
        else $error("valid readback did not move to lf wait");

    a_cr_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (o_result.position_valid || o_result.range_error) |=> r_digit_count == '0)
        else $error("digit count not cleared after cr");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> int'(r_digit_count) <= DIGIT_SLOTS)
        else $error("digit count beyond slots");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_digit_count) && $stable(r_step))
        else $error("parser state moved without a transfer");
`endif

endmodule

`default_nettype wire

@@ design/servo_ascii_reply_parser.sv @@
// servo_ascii_reply_parser: matcher for servo serial replies
// depends on srap_pkg, srap_if, srap_match
//
// i_rx carries one received byte per transfer; o_res carries one result per
// byte: ack_seen, position_valid with position, range_error, readback_done.
// i_cfg_we / i_cfg_wdata write position_limit, the largest accepted value.
// A byte is taken into an input register, parsed by single-level logic and
// the result lands in an output register; one byte per cycle is sustained
// since i_rx.ready stays high while the output register is empty or being
// taken.
// Parser state advances only when a byte moves into the output register.
// When o_res.ready is low the result holds, one more byte is taken into the
// input register, and then i_rx.ready drops until the stall clears.
// Reset (synchronous, active low) empties both registers, returns the match
// to idle, clears the digit count and sets position_limit to 4095.
`default_nettype none

module servo_ascii_reply_parser (
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    srap_rx_if.sink              i_rx,
    srap_res_if.source           o_res,
    input  var logic             i_cfg_we,
    input  var srap_pkg::t_limit i_cfg_wdata
);
    import srap_pkg::*;

    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_out_valid;
    t_result r_res;
    t_limit  r_position_limit;
    t_result res;
    logic    out_free;
    logic    fire;

    assign out_free   = !r_out_valid || o_res.ready;
    assign fire       = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    srap_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_limit  (r_position_limit),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_position_limit <= LIMIT_RESET;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_position_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.ack_seen       = r_res.ack_seen;
    assign o_res.position_valid = r_res.position_valid;
    assign o_res.position       = r_res.position;
    assign o_res.range_error    = r_res.range_error;
    assign o_res.readback_done  = r_res.readback_done;

endmodule

`default_nettype wire
